// ===== src/segment_pose_at_distance_macros.svh =====
// ----------------------------------------------------------------------------
// Segment pose assertion macros
// Shared same-cycle implication and next-cycle property forms.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_POSE_AT_DISTANCE_MACROS_SVH
`define SEGMENT_POSE_AT_DISTANCE_MACROS_SVH

// same-cycle implication
`define SPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/spa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pose package
// Widths, fixed-point constants, CORDIC table and shared types.
// ----------------------------------------------------------------------------
package spa_pkg;

	localparam int CW            = 24;
	localparam int FB            = 16;
	localparam int LW            = CW - 1;
	localparam int CORDIC_STAGES = 20;
	localparam int DIV_BITS      = LW + FB;
	localparam int ANG_W         = DIV_BITS + 2;
	localparam int RED_W         = ANG_W + 1;
	localparam int RED_STEPS     = 24;
	localparam int RW            = 20;
	localparam int ZW            = 34;
	localparam int PW            = 24 + ZW;
	localparam int QD            = 4;
	localparam int QA            = 2;

	localparam longint Q30_PI   = 64'd3373259426;
	localparam longint Q30_GAIN = 64'd652032874;
	localparam longint PI_Q     = (Q30_PI + (64'd1 << (29 - FB))) >> (30 - FB);
	localparam longint HPI_Q    = (Q30_PI + (64'd1 << (30 - FB))) >> (31 - FB);
	localparam longint TWO_PI_Q = 2 * PI_Q;
	localparam longint RED_OFFS = (((64'd1 << (ANG_W - 1)) / TWO_PI_Q) + 64'd1) * TWO_PI_Q;

	localparam logic [LW-1:0] LMAX = '1;

	localparam logic [2:0] REG_KIND  = 3'd0;
	localparam logic [2:0] REG_OX    = 3'd1;
	localparam logic [2:0] REG_OY    = 3'd2;
	localparam logic [2:0] REG_OZ    = 3'd3;
	localparam logic [2:0] REG_EXT   = 3'd4;
	localparam logic [2:0] REG_SA    = 3'd5;
	localparam logic [2:0] REG_EA    = 3'd6;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_ZERO_RADIUS = 2'd1;
	localparam logic [1:0] ST_SAT         = 2'd2;

	typedef struct packed {
		logic                 kind;
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic signed [CW-1:0] oz;
		logic [LW-1:0]        ext;
		logic signed [CW-1:0] sa;
		logic signed [CW-1:0] ea;
	} cfg_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] ang;
		logic [LW-1:0]           arc_len;
	} qent_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] v;
		unique case (i)
			0: v = 34'sd843314856;
			1: v = 34'sd497837829;
			2: v = 34'sd263043836;
			3: v = 34'sd133525158;
			4: v = 34'sd67021686;
			5: v = 34'sd33543515;
			6: v = 34'sd16775850;
			7: v = 34'sd8388437;
			8: v = 34'sd4194282;
			9: v = 34'sd2097149;
			10: v = 34'sd1048575;
			11: v = 34'sd524287;
			12: v = 34'sd262143;
			13: v = 34'sd131071;
			14: v = 34'sd65535;
			15: v = 34'sd32767;
			16: v = 34'sd16383;
			17: v = 34'sd8191;
			18: v = 34'sd4095;
			19: v = 34'sd2047;
			20: v = 34'sd1023;
			21: v = 34'sd511;
			22: v = 34'sd255;
			23: v = 34'sd127;
			24: v = 34'sd63;
			25: v = 34'sd31;
			26: v = 34'sd15;
			27: v = 34'sd8;
			28: v = 34'sd4;
			29: v = 34'sd2;
			30: v = 34'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// clamp to the signed coordinate range; top bit flags saturation
	function automatic logic [CW:0] clamp_s(input logic signed [RED_W-1:0] v);
		logic signed [RED_W-1:0] hi;
		logic signed [RED_W-1:0] lo;
		logic [CW:0]             r;
		hi = RED_W'((64'd1 << (CW - 1)) - 64'd1);
		lo = -hi - RED_W'(1);
		if (v > hi) begin
			r = {1'b1, hi[CW-1:0]};
		end else if (v < lo) begin
			r = {1'b1, lo[CW-1:0]};
		end else begin
			r = {1'b0, v[CW-1:0]};
		end
		return r;
	endfunction

endpackage

// ===== src/spa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pose divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module spa_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [spa_pkg::LW-1:0] arc_len,
	input  logic [spa_pkg::LW-1:0] ext,
	output logic                   out_valid,
	output logic [spa_pkg::LW-1:0] out_dist,
	output logic [spa_pkg::DIV_BITS-1:0] out_quo
);
	import spa_pkg::*;

	logic                vld_q  [DIV_BITS+1];
	logic [LW-1:0]       dist_q [DIV_BITS+1];
	logic [LW-1:0]       rem_q  [DIV_BITS+1];
	logic [DIV_BITS-1:0] quo_q  [DIV_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		dist_q[0] <= arc_len;
		rem_q[0]  <= '0;
		quo_q[0]  <= '0;
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
		localparam int B = DIV_BITS - 1 - k;
		logic        dbit;
		logic [LW:0] trial;
		logic        fit;

		if (B >= FB) begin : g_data
			assign dbit = dist_q[k][B-FB];
		end else begin : g_zero
			assign dbit = 1'b0;
		end

		assign trial = {rem_q[k], dbit};
		assign fit   = trial >= {1'b0, ext};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			dist_q[k+1] <= dist_q[k];
			rem_q[k+1]  <= fit ? LW'(trial - {1'b0, ext}) : trial[LW-1:0];
			quo_q[k+1]  <= {quo_q[k][DIV_BITS-2:0], fit};
		end
	end

	assign out_valid = vld_q[DIV_BITS];
	assign out_dist  = dist_q[DIV_BITS];
	assign out_quo   = quo_q[DIV_BITS];

endmodule

// ===== src/spa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pose front end
// Accepts distances, divides by the radius and forms the point angle.
// ----------------------------------------------------------------------------
module spa_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [spa_pkg::LW-1:0] distance,
	input  spa_pkg::cfg_t          cfg,
	output logic                   push,
	output spa_pkg::qent_t         entry
);
	import spa_pkg::*;

	logic                    div_vld;
	logic [LW-1:0]           div_dist;
	logic [DIV_BITS-1:0]     div_quo;
	logic [DIV_BITS-1:0]     turn;
	logic signed [ANG_W-1:0] sa_w;
	logic signed [ANG_W-1:0] turn_w;
	logic signed [ANG_W-1:0] ang;
	logic                    cw;
	logic                    push_q;
	qent_t                   entry_q;

	spa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.arc_len   (distance),
		.ext       (cfg.ext),
		.out_valid (div_vld),
		.out_dist  (div_dist),
		.out_quo   (div_quo)
	);

	always_comb begin
		turn   = (cfg.ext == '0) ? '0 : div_quo;
		sa_w   = ANG_W'(cfg.sa);
		turn_w = $signed({2'b00, turn});
		cw     = cfg.ea < cfg.sa;
		if (!cfg.kind) begin
			ang = sa_w;
		end else if (cw) begin
			ang = sa_w - turn_w;
		end else begin
			ang = sa_w + turn_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_q <= 1'b0;
		end else begin
			push_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		entry_q.ang     <= ang;
		entry_q.arc_len <= div_dist;
	end

	assign push  = push_q;
	assign entry = entry_q;

endmodule

// ===== src/spa_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pose queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module spa_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  spa_pkg::qent_t wdata,
	input  logic           pop,
	output spa_pkg::qent_t rdata,
	output logic           empty,
	output logic           full
);
	import spa_pkg::*;

	qent_t         mem_q [QD];
	logic [QA-1:0] wr_q;
	logic [QA-1:0] rd_q;
	logic [QA:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = cnt_q == '0;
	assign full    = cnt_q == (QA+1)'(QD);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QA'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QA'(1);
			end
			cnt_q <= cnt_q + (QA+1)'(do_push) - (QA+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== src/spa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pose back end
// Angle reduction, CORDIC sine and cosine, scaling and saturation.
// ----------------------------------------------------------------------------
module spa_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  spa_pkg::qent_t         entry,
	input  spa_pkg::cfg_t          cfg,
	output logic                   done,
	output logic [spa_pkg::CW-1:0] pos_x,
	output logic [spa_pkg::CW-1:0] pos_y,
	output logic [spa_pkg::CW-1:0] pos_z,
	output logic [spa_pkg::CW-1:0] heading,
	output logic [spa_pkg::LW-1:0] seg_length,
	output logic [1:0]             status
);
	import spa_pkg::*;

	// angle reduction
	logic             red_vld_q [RED_STEPS+1];
	logic [RED_W-1:0] red_u_q   [RED_STEPS+1];
	qent_t            red_p_q   [RED_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_vld_q[0] <= 1'b0;
		end else begin
			red_vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		red_u_q[0] <= RED_W'(entry.ang) + RED_W'(RED_OFFS);
		red_p_q[0] <= entry;
	end

	for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
		localparam logic [RED_W-1:0] SUB = RED_W'(TWO_PI_Q) << (RED_STEPS - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				red_vld_q[k+1] <= 1'b0;
			end else begin
				red_vld_q[k+1] <= red_vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			red_u_q[k+1] <= (red_u_q[k] >= SUB) ? red_u_q[k] - SUB : red_u_q[k];
			red_p_q[k+1] <= red_p_q[k];
		end
	end

	// fold into the CORDIC range
	logic signed [RW-1:0] s0;
	logic signed [RW-1:0] s1;
	logic signed [RW-1:0] s2;
	logic                 fold;

	always_comb begin
		s0   = $signed({1'b0, red_u_q[RED_STEPS][RW-2:0]});
		s1   = (s0 >= RW'(PI_Q)) ? s0 - RW'(TWO_PI_Q) : s0;
		s2   = s1;
		fold = 1'b0;
		if (s1 > RW'(HPI_Q)) begin
			s2   = s1 - RW'(PI_Q);
			fold = 1'b1;
		end else if (s1 < -RW'(HPI_Q)) begin
			s2   = s1 + RW'(PI_Q);
			fold = 1'b1;
		end
	end

	logic                 cor_vld_q [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cor_x_q   [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cor_y_q   [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cor_z_q   [CORDIC_STAGES+1];
	logic                 cor_n_q   [CORDIC_STAGES+1];
	qent_t                cor_p_q   [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cor_vld_q[0] <= 1'b0;
		end else begin
			cor_vld_q[0] <= red_vld_q[RED_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		cor_x_q[0] <= ZW'(Q30_GAIN);
		cor_y_q[0] <= '0;
		cor_z_q[0] <= ZW'(s2) <<< (30 - FB);
		cor_n_q[0] <= fold;
		cor_p_q[0] <= red_p_q[RED_STEPS];
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
		localparam logic signed [ZW-1:0] ATN = atan_q30(i);
		logic                 up;
		logic signed [ZW-1:0] xs;
		logic signed [ZW-1:0] ys;

		assign up = cor_z_q[i] >= 0;
		assign xs = cor_x_q[i] >>> i;
		assign ys = cor_y_q[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cor_vld_q[i+1] <= 1'b0;
			end else begin
				cor_vld_q[i+1] <= cor_vld_q[i];
			end
		end

		always_ff @(posedge clk) begin
			cor_x_q[i+1] <= up ? cor_x_q[i] - ys : cor_x_q[i] + ys;
			cor_y_q[i+1] <= up ? cor_y_q[i] + xs : cor_y_q[i] - xs;
			cor_z_q[i+1] <= up ? cor_z_q[i] - ATN : cor_z_q[i] + ATN;
			cor_n_q[i+1] <= cor_n_q[i];
			cor_p_q[i+1] <= cor_p_q[i];
		end
	end

	// scale
	logic signed [ZW-1:0]    cosv;
	logic signed [ZW-1:0]    sinv;
	logic signed [CW-1:0]    mult;
	logic [CW:0]             mag;
	logic signed [CW:0]      dang;
	logic                    vld_s1;
	logic signed [PW-1:0]    px_s1;
	logic signed [PW-1:0]    py_s1;
	logic [LW+CW:0]          len_s1;
	logic signed [ANG_W-1:0] ang_s1;

	always_comb begin
		cosv = cor_n_q[CORDIC_STAGES] ? -cor_x_q[CORDIC_STAGES] : cor_x_q[CORDIC_STAGES];
		sinv = cor_n_q[CORDIC_STAGES] ? -cor_y_q[CORDIC_STAGES] : cor_y_q[CORDIC_STAGES];
		mult = $signed({1'b0, cfg.kind ? cfg.ext : cor_p_q[CORDIC_STAGES].arc_len});
		dang = (CW+1)'(cfg.sa) - (CW+1)'(cfg.ea);
		mag  = (dang < 0) ? $unsigned(-dang) : $unsigned(dang);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cor_vld_q[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		px_s1  <= PW'(mult) * PW'(cosv);
		py_s1  <= PW'(mult) * PW'(sinv);
		len_s1 <= (LW+CW+1)'(cfg.ext) * (LW+CW+1)'(mag);
		ang_s1 <= cor_p_q[CORDIC_STAGES].ang;
	end

	// round, offset, clamp
	logic signed [PW-1:0]    rx;
	logic signed [PW-1:0]    ry;
	logic [CW:0]             cx;
	logic [CW:0]             cy;
	logic [CW:0]             ch;
	logic signed [RED_W-1:0] hang;
	logic [LW+CW:0]          lr;
	logic [LW-1:0]           len;
	logic                    lsat;
	logic                    sat;
	logic [1:0]              st;
	logic                    done_q;
	logic [CW-1:0]           px_q;
	logic [CW-1:0]           py_q;
	logic [CW-1:0]           pz_q;
	logic [CW-1:0]           hd_q;
	logic [LW-1:0]           len_q;
	logic [1:0]              st_q;

	always_comb begin
		rx = ((px_s1 + (PW'(1) <<< 29)) >>> 30) + PW'(cfg.ox);
		ry = ((py_s1 + (PW'(1) <<< 29)) >>> 30) + PW'(cfg.oy);
		cx = clamp_s(RED_W'(rx));
		cy = clamp_s(RED_W'(ry));
		if (cfg.ea < cfg.sa) begin
			hang = RED_W'(ang_s1) - RED_W'(HPI_Q);
		end else begin
			hang = RED_W'(ang_s1) + RED_W'(HPI_Q);
		end
		ch   = clamp_s(hang);
		lr   = (len_s1 + (LW+CW+1)'(1 << (FB - 1))) >> FB;
		lsat = lr > (LW+CW+1)'(LMAX);
		len  = lsat ? LMAX : lr[LW-1:0];
		if (!cfg.kind) begin
			sat = cx[CW] || cy[CW];
			st  = sat ? ST_SAT : ST_OK;
		end else begin
			sat = cx[CW] || cy[CW] || ch[CW] || lsat;
			if (cfg.ext == '0) begin
				st = ST_ZERO_RADIUS;
			end else begin
				st = sat ? ST_SAT : ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_q  <= cx[CW-1:0];
		py_q  <= cy[CW-1:0];
		pz_q  <= cfg.oz;
		hd_q  <= cfg.kind ? ch[CW-1:0] : cfg.sa;
		len_q <= cfg.kind ? len : cfg.ext;
		st_q  <= st;
	end

	assign done       = done_q;
	assign pos_x      = px_q;
	assign pos_y      = py_q;
	assign pos_z      = pz_q;
	assign heading    = hd_q;
	assign seg_length = len_q;
	assign status     = st_q;

endmodule

// ===== src/segment_pose_at_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pose at distance
// Pose on a configured line or arc segment for each arc-length distance.
// ----------------------------------------------------------------------------
// One distance may be started every clock cycle while busy is low, and each
// gives one result, strobed by done for a single cycle, after it has passed
// through a 39-stage radius divider, a 24-stage angle reduction and a 20-stage
// CORDIC. The receiver cannot stall, so busy stays low in normal use. Write the
// segment registers only when no distance is in flight.
module segment_pose_at_distance (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [spa_pkg::LW-1:0] distance,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [spa_pkg::CW-1:0] cfg_data,
	output logic                   done,
	output logic [spa_pkg::CW-1:0] pos_x,
	output logic [spa_pkg::CW-1:0] pos_y,
	output logic [spa_pkg::CW-1:0] pos_z,
	output logic [spa_pkg::CW-1:0] heading,
	output logic [spa_pkg::LW-1:0] seg_length,
	output logic [1:0]             status
);
	import spa_pkg::*;
	`include "segment_pose_at_distance_macros.svh"

	cfg_t  cfg_q;
	logic  push;
	qent_t q_in;
	qent_t q_out;
	logic  q_empty;
	logic  q_full;

	assign cfg_ready = 1'b1;
	assign busy      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KIND: cfg_q.kind <= cfg_data[0];
				REG_OX:   cfg_q.ox   <= cfg_data;
				REG_OY:   cfg_q.oy   <= cfg_data;
				REG_OZ:   cfg_q.oz   <= cfg_data;
				REG_EXT:  cfg_q.ext  <= cfg_data[LW-1:0];
				REG_SA:   cfg_q.sa   <= cfg_data;
				REG_EA:   cfg_q.ea   <= cfg_data;
				default: ;
			endcase
		end
	end

	spa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (start && !busy),
		.distance (distance),
		.cfg      (cfg_q),
		.push     (push),
		.entry    (q_in)
	);

	spa_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_in),
		.pop    (!q_empty),
		.rdata  (q_out),
		.empty  (q_empty),
		.full   (q_full)
	);

	spa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!q_empty),
		.entry      (q_out),
		.cfg        (cfg_q),
		.done       (done),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.heading    (heading),
		.seg_length (seg_length),
		.status     (status)
	);

	`SPA_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !q_full, "queue overflow")
	`SPA_ASSERT_NEXT(a_push_lands, clk, arst_n, push && q_empty, !q_empty, "transfer lost")
	`SPA_ASSERT_IMPL(a_zero_radius, clk, arst_n, done && cfg_q.kind && cfg_q.ext == '0, status == ST_ZERO_RADIUS, "zero radius not flagged")
	`SPA_ASSERT_IMPL(a_line_status, clk, arst_n, done && !cfg_q.kind, status != ST_ZERO_RADIUS, "line flagged as zero radius")

endmodule
